// ===== rtl/bmff_pkg.sv =====
// Package: shared constants and types for the bitmap range find-and-fill block.
`default_nettype none
package bmff_pkg;

  localparam int MAP_WORDS_DEF = 64;
  localparam int WORD_BITS_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int START_W  = 12;
  localparam int END_W    = 13;
  localparam int POS_W    = 12;
  localparam int POS_LIMIT = 2 ** END_W - 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIND  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/bmff_req_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface bmff_req_if;
  logic                           valid;
  logic                           ready;
  logic [bmff_pkg::ACTION_W-1:0]  action;
  logic [bmff_pkg::START_W-1:0]   range_start;
  logic [bmff_pkg::END_W-1:0]     range_end;

  modport source (output valid, action, range_start, range_end, input ready);
  modport sink (input valid, action, range_start, range_end, output ready);
endinterface

interface bmff_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [bmff_pkg::POS_W-1:0]   found_position;

  modport source (output valid, found, found_position, input ready);
  modport sink (input valid, found, found_position, output ready);
endinterface
`default_nettype wire

// ===== rtl/bitmap_range_find_and_fill_top.sv =====
// Top level: bitmap range find-and-fill with a word-serial walk over the map memory.
// Walk: reads words 0 .. N-1, N = ceil(min(range_end, map size) / WORD_BITS) or up
//   to the word of a find hit, one word per registered read; the result passes through
//   the finish state to the registered response. Empty range or unused action: no walk.
// Requests: one in flight; the next is taken only after the response is loaded.
// Reset: asynchronous, active low; then a clearing pass over all map words, request not ready.
`default_nettype none
module bitmap_range_find_and_fill_top #(
  parameter int MAP_WORDS = bmff_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS = bmff_pkg::WORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bmff_req_if.sink    req_i,
  bmff_rsp_if.source  rsp_o
);

  localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;
  localparam int LIMIT = (TOTAL_BITS < bmff_pkg::POS_LIMIT) ? TOTAL_BITS : bmff_pkg::POS_LIMIT;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OW = $clog2(WORD_BITS + 1);
  localparam int BW = bmff_pkg::END_W + 1;
  localparam int EW = bmff_pkg::END_W;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  bmff_pkg::state_e state_q, state_d;

  logic [bmff_pkg::ACTION_W-1:0] act_q, act_d;
  logic [EW-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [BW-1:0]        base_q, base_d;
  logic [AW-1:0]        w_q, w_d;
  logic                 iss_act_q, iss_act_d;
  logic                 p_vld_q, p_vld_d;
  logic                 p_last_q, p_last_d;
  logic [BW-1:0]        p_base_q, p_base_d;
  logic [AW-1:0]        p_addr_q, p_addr_d;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 res_found_q, res_found_d;
  logic [bmff_pkg::POS_W-1:0] res_pos_q, res_pos_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_found_q;
  logic [bmff_pkg::POS_W-1:0] out_pos_q;

  logic [EW-1:0]        lo_c, hi_c;
  logic                 req_fire, walk_start, iss_last, out_free, out_load;
  logic                 is_find, is_fill;
  logic [BW-1:0]        lo_b, hi_b, wb_b, lo_diff, hi_diff, hit_pos;
  logic [OW-1:0]        s_off, e_off, hit_off;
  logic [WORD_BITS-1:0] mask, masked, fill_word;
  logic                 hit, done_now;

  logic                 req_ready;
  logic                 issue_en;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Request decode and clamping
  assign lo_c = ({1'b0, req_i.range_start} > EW'(LIMIT)) ? EW'(LIMIT)
                                                          : {1'b0, req_i.range_start};
  assign hi_c = (req_i.range_end > EW'(LIMIT)) ? EW'(LIMIT) : req_i.range_end;
  assign req_fire   = req_i.valid && req_ready;
  assign walk_start = (lo_c < hi_c) &&
                      (req_i.action inside {bmff_pkg::ACT_FIND, bmff_pkg::ACT_SET,
                                            bmff_pkg::ACT_CLEAR});

  assign is_find = (act_q == bmff_pkg::ACT_FIND);
  assign is_fill = !is_find;

  // Word processing stage
  assign lo_b    = BW'(lo_q);
  assign hi_b    = BW'(hi_q);
  assign wb_b    = BW'(WORD_BITS);
  assign lo_diff = lo_b - p_base_q;
  assign hi_diff = hi_b - p_base_q;
  assign iss_last = (base_q + wb_b) >= hi_b;

  always_comb begin
    if (lo_b <= p_base_q) begin
      s_off = '0;
    end else if (lo_diff >= wb_b) begin
      s_off = OW'(WORD_BITS);
    end else begin
      s_off = OW'(lo_diff);
    end
    if (hi_b <= p_base_q) begin
      e_off = '0;
    end else if (hi_diff >= wb_b) begin
      e_off = OW'(WORD_BITS);
    end else begin
      e_off = OW'(hi_diff);
    end
  end

  // Bit b of a word holds in-word offset WORD_BITS-1-b (MSB-first numbering)
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (OW'(WORD_BITS - 1 - b) >= s_off) && (OW'(WORD_BITS - 1 - b) < e_off);
    end
  end

  assign masked    = rdata_q & mask;
  assign fill_word = (act_q == bmff_pkg::ACT_SET) ? (rdata_q | mask) : (rdata_q & ~mask);
  assign hit       = |masked;

  always_comb begin
    hit_off = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (masked[b]) begin
        hit_off = OW'(WORD_BITS - 1 - b);
      end
    end
  end

  assign hit_pos  = p_base_q + BW'(hit_off);
  assign done_now = p_vld_q && (p_last_q || (is_find && hit));
  assign out_free = !out_vld_q || rsp_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmff_pkg::S_CLEAR: begin
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = bmff_pkg::S_IDLE;
        end
      end
      bmff_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = walk_start ? bmff_pkg::S_WALK : bmff_pkg::S_FINISH;
        end
      end
      bmff_pkg::S_WALK: begin
        if (done_now) begin
          state_d = bmff_pkg::S_FINISH;
        end
      end
      bmff_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = bmff_pkg::S_IDLE;
        end
      end
      default: state_d = bmff_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_ready = 1'b0;
    issue_en  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = p_addr_q;
    wr_data   = fill_word;
    out_load  = 1'b0;
    case (state_q)
      bmff_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      bmff_pkg::S_IDLE: begin
        req_ready = 1'b1;
      end
      bmff_pkg::S_WALK: begin
        issue_en = iss_act_q && !done_now;
        wr_en    = p_vld_q && is_fill;
      end
      bmff_pkg::S_FINISH: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    act_d       = act_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    base_d      = base_q;
    w_d         = w_q;
    iss_act_d   = iss_act_q;
    p_vld_d     = issue_en;
    p_last_d    = iss_last;
    p_base_d    = base_q;
    p_addr_d    = w_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    clr_d       = clr_q;
    out_vld_d   = out_vld_q;
    if (state_q == bmff_pkg::S_CLEAR) begin
      clr_d = clr_q + AW'(1);
    end
    if (req_fire) begin
      act_d       = req_i.action;
      lo_d        = lo_c;
      hi_d        = hi_c;
      base_d      = '0;
      w_d         = '0;
      iss_act_d   = walk_start;
      res_found_d = 1'b0;
      res_pos_d   = '0;
    end
    if (issue_en) begin
      base_d    = base_q + wb_b;
      w_d       = w_q + AW'(1);
      iss_act_d = !iss_last;
    end
    if (done_now) begin
      iss_act_d   = 1'b0;
      res_found_d = is_find && hit;
      res_pos_d   = (is_find && hit) ? hit_pos[bmff_pkg::POS_W-1:0] : '0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmff_pkg::S_CLEAR;
      clr_q       <= '0;
      iss_act_q   <= 1'b0;
      p_vld_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      res_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_act_q   <= iss_act_d;
      p_vld_q     <= p_vld_d;
      out_vld_q   <= out_vld_d;
      res_found_q <= res_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    base_q    <= base_d;
    w_q       <= w_d;
    p_last_q  <= p_last_d;
    p_base_q  <= p_base_d;
    p_addr_q  <= p_addr_d;
    res_pos_q <= res_pos_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  // Map memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rdata_q <= mem[w_q];
    end
  end

  assign req_i.ready          = req_ready;
  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.found          = out_found_q;
  assign rsp_o.found_position = out_pos_q;

  a_pipe_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> $past(state_q) == bmff_pkg::S_WALK)
    else $error("word stage valid outside a walk");

  a_rsp_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == bmff_pkg::S_FINISH)
    else $error("response raised outside finish");

  a_found_only_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmff_pkg::S_FINISH && res_found_q) |-> act_q == bmff_pkg::ACT_FIND)
    else $error("found flag on a fill request");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && issue_en) |-> wr_addr != w_q)
    else $error("read and write to the same word in one cycle");

endmodule
`default_nettype wire
